### rtl/c8x_pkg.sv
package c8x_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SIDX_W      = $clog2(STACK_DEPTH);

  localparam logic [11:0] PC_RESET = 12'h200;

  localparam logic [3:0] OP_SYS   = 4'h0;
  localparam logic [3:0] OP_JP    = 4'h1;
  localparam logic [3:0] OP_CALL  = 4'h2;
  localparam logic [3:0] OP_SE_I  = 4'h3;
  localparam logic [3:0] OP_SNE_I = 4'h4;
  localparam logic [3:0] OP_SE_R  = 4'h5;
  localparam logic [3:0] OP_LD_I  = 4'h6;
  localparam logic [3:0] OP_ADD_I = 4'h7;
  localparam logic [3:0] OP_ALU   = 4'h8;
  localparam logic [3:0] OP_SNE_R = 4'h9;
  localparam logic [3:0] OP_LD_IX = 4'hA;
  localparam logic [3:0] OP_JP_V0 = 4'hB;
  localparam logic [3:0] OP_RND   = 4'hC;
  localparam logic [3:0] OP_DRW   = 4'hD;
  localparam logic [3:0] OP_KEY   = 4'hE;
  localparam logic [3:0] OP_MISC  = 4'hF;

  localparam logic [3:0] ALU_LD   = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [15:0] INS_CLS = 16'h00E0;
  localparam logic [15:0] INS_RET = 16'h00EE;

  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  localparam logic [7:0] FN_LD_VX_DT = 8'h07;
  localparam logic [7:0] FN_LD_K     = 8'h0A;
  localparam logic [7:0] FN_LD_DT    = 8'h15;
  localparam logic [7:0] FN_LD_ST    = 8'h18;
  localparam logic [7:0] FN_ADD_I    = 8'h1E;
  localparam logic [7:0] FN_LD_F     = 8'h29;
  localparam logic [7:0] FN_LD_B     = 8'h33;
  localparam logic [7:0] FN_ST_REGS  = 8'h55;
  localparam logic [7:0] FN_LD_REGS  = 8'h65;

  localparam logic [3:0] REG_FLAG = 4'hF;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNKNOWN     = 3'd1,
    ST_UNSUPPORTED = 3'd2,
    ST_OVERFLOW    = 3'd3,
    ST_UNDERFLOW   = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0]      vx;
    logic [7:0]      vy;
    logic [7:0]      v0;
    logic [7:0]      vf;
    logic [11:0]     pc;
    logic [11:0]     index;
    logic [SP_W-1:0] sp;
    logic [11:0]     stack_top;
    logic [7:0]      delay;
    logic [7:0]      sound;
  } view_t;

  typedef struct packed {
    logic        reg_we;
    logic [3:0]  reg_num;
    logic [7:0]  reg_data;
    logic        flag_we;
    logic [7:0]  flag_data;
    logic [11:0] pc;
    logic        index_we;
    logic [11:0] index;
    logic        push;
    logic        pop;
    logic [11:0] push_data;
    logic        delay_we;
    logic        sound_we;
    logic [7:0]  timer_data;
  } update_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic [2:0]  status;
    logic [11:0] index_value;
    logic        reg_write_enable;
    logic [3:0]  reg_write_number;
    logic [7:0]  reg_write_data;
    logic [7:0]  flag_value;
    logic [7:0]  delay_value;
    logic [7:0]  sound_value;
  } result_t;

endpackage

### rtl/c8x_exec.sv
module c8x_exec (
  input  logic [15:0]      instr_i,
  input  logic [7:0]       rnd_i,
  input  c8x_pkg::view_t   view_i,
  output c8x_pkg::update_t upd_o,
  output c8x_pkg::result_t res_o
);
  import c8x_pkg::*;

  logic [3:0]  top;
  logic [3:0]  x;
  logic [3:0]  n;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic [11:0] pc2;
  logic [11:0] pc4;
  logic [8:0]  sum;
  status_e     st;
  logic        wr;
  logic [7:0]  wval;
  logic        fwr;
  logic [7:0]  fval;
  logic [11:0] npc;
  logic        idx_we;
  logic        push;
  logic        pop;
  logic        dly_we;
  logic        snd_we;
  logic        x_is_f;
  logic [7:0]  rep_data;
  logic [7:0]  flag_after;

  assign top    = instr_i[15:12];
  assign x      = instr_i[11:8];
  assign n      = instr_i[3:0];
  assign nn     = instr_i[7:0];
  assign nnn    = instr_i[11:0];
  assign pc2    = view_i.pc + 12'd2;
  assign pc4    = view_i.pc + 12'd4;
  assign sum    = {1'b0, view_i.vx} + {1'b0, view_i.vy};
  assign x_is_f = (x == REG_FLAG);

  always_comb begin
    st     = ST_OK;
    wr     = 1'b0;
    wval   = 8'd0;
    fwr    = 1'b0;
    fval   = 8'd0;
    npc    = pc2;
    idx_we = 1'b0;
    push   = 1'b0;
    pop    = 1'b0;
    dly_we = 1'b0;
    snd_we = 1'b0;
    case (top)
      OP_SYS: begin
        if (instr_i == INS_CLS) begin
          st = ST_UNSUPPORTED;
        end else if (instr_i == INS_RET) begin
          if (view_i.sp == '0) begin
            st = ST_UNDERFLOW;
          end else begin
            pop = 1'b1;
            npc = view_i.stack_top;
          end
        end else begin
          st = ST_UNKNOWN;
        end
      end
      OP_JP: npc = nnn;
      OP_CALL: begin
        if (view_i.sp >= SP_W'(STACK_DEPTH)) begin
          st = ST_OVERFLOW;
        end else begin
          push = 1'b1;
          npc  = nnn;
        end
      end
      OP_SE_I:  npc = (view_i.vx == nn) ? pc4 : pc2;
      OP_SNE_I: npc = (view_i.vx != nn) ? pc4 : pc2;
      OP_SE_R:  npc = (view_i.vx == view_i.vy) ? pc4 : pc2;
      OP_SNE_R: npc = (view_i.vx != view_i.vy) ? pc4 : pc2;
      OP_LD_I: begin
        wr   = 1'b1;
        wval = nn;
      end
      OP_ADD_I: begin
        // add into the flag register is dropped
        if (!x_is_f) begin
          wr   = 1'b1;
          wval = view_i.vx + nn;
        end
      end
      OP_ALU: begin
        case (n)
          ALU_LD: begin
            wr   = 1'b1;
            wval = view_i.vy;
          end
          ALU_OR: begin
            wr   = 1'b1;
            wval = view_i.vx | view_i.vy;
          end
          ALU_AND: begin
            wr   = 1'b1;
            wval = view_i.vx & view_i.vy;
          end
          ALU_XOR: begin
            wr   = 1'b1;
            wval = view_i.vx ^ view_i.vy;
          end
          ALU_ADD: begin
            wr   = 1'b1;
            wval = sum[7:0];
            fwr  = 1'b1;
            fval = {7'd0, sum[8]};
          end
          ALU_SUB: begin
            wr   = 1'b1;
            wval = view_i.vx - view_i.vy;
            fwr  = 1'b1;
            fval = {7'd0, view_i.vx >= view_i.vy};
          end
          ALU_SHR: begin
            wr   = 1'b1;
            wval = {1'b0, view_i.vx[7:1]};
            fwr  = 1'b1;
            fval = {7'd0, view_i.vx[0]};
          end
          ALU_SUBN: begin
            wr   = 1'b1;
            wval = view_i.vy - view_i.vx;
            fwr  = 1'b1;
            fval = {7'd0, view_i.vy >= view_i.vx};
          end
          ALU_SHL: begin
            wr   = 1'b1;
            wval = {view_i.vx[6:0], 1'b0};
            fwr  = 1'b1;
            fval = {7'd0, view_i.vx[7]};
          end
          default: st = ST_UNKNOWN;
        endcase
      end
      OP_LD_IX: idx_we = 1'b1;
      OP_JP_V0: npc = {4'd0, view_i.v0} + nnn;
      OP_RND: begin
        wr   = 1'b1;
        wval = rnd_i & nn;
      end
      OP_DRW: st = ST_UNSUPPORTED;
      OP_KEY: st = (nn == KEY_SKP || nn == KEY_SKNP) ? ST_UNSUPPORTED : ST_UNKNOWN;
      OP_MISC: begin
        case (nn)
          FN_LD_VX_DT: begin
            wr   = 1'b1;
            wval = view_i.delay;
          end
          FN_LD_DT: dly_we = 1'b1;
          FN_LD_ST: snd_we = 1'b1;
          FN_LD_K, FN_ADD_I, FN_LD_F, FN_LD_B, FN_ST_REGS, FN_LD_REGS: st = ST_UNSUPPORTED;
          default: st = ST_UNKNOWN;
        endcase
      end
      default: st = ST_UNKNOWN;
    endcase
    // faults leave everything as it was
    if (st inside {ST_UNKNOWN, ST_OVERFLOW, ST_UNDERFLOW}) begin
      npc = view_i.pc;
      wr  = 1'b0;
      fwr = 1'b0;
    end
  end

  // flag write wins over the register write when x is the flag register
  assign rep_data   = (fwr && x_is_f) ? fval : wval;
  assign flag_after = fwr ? fval : ((wr && x_is_f) ? wval : view_i.vf);

  always_comb begin
    upd_o.reg_we     = wr;
    upd_o.reg_num    = x;
    upd_o.reg_data   = wval;
    upd_o.flag_we    = fwr;
    upd_o.flag_data  = fval;
    upd_o.pc         = npc;
    upd_o.index_we   = idx_we;
    upd_o.index      = nnn;
    upd_o.push       = push;
    upd_o.pop        = pop;
    upd_o.push_data  = pc2;
    upd_o.delay_we   = dly_we;
    upd_o.sound_we   = snd_we;
    upd_o.timer_data = view_i.vx;

    res_o.next_pc          = npc;
    res_o.status           = st;
    res_o.index_value      = idx_we ? nnn : view_i.index;
    res_o.reg_write_enable = wr;
    res_o.reg_write_number = wr ? x : 4'd0;
    res_o.reg_write_data   = wr ? rep_data : 8'd0;
    res_o.flag_value       = flag_after;
    res_o.delay_value      = dly_we ? view_i.vx : view_i.delay;
    res_o.sound_value      = snd_we ? view_i.vx : view_i.sound;
  end

endmodule

### rtl/c8x_state.sv
module c8x_state (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             commit_i,
  input  logic [3:0]       rd_x_i,
  input  logic [3:0]       rd_y_i,
  input  c8x_pkg::update_t upd_i,
  output c8x_pkg::view_t   view_o
);
  import c8x_pkg::*;

  // two copies of the register file: copy a feeds vx, v0 and vf, copy b feeds vy
  logic [7:0]        regs_a_q [16];
  logic [7:0]        regs_b_q [16];
  logic [11:0]       stack_q  [STACK_DEPTH];
  logic [11:0]       index_q;
  logic [11:0]       pc_q;
  logic [SP_W-1:0]   sp_q;
  logic [SP_W-1:0]   sp_m1;
  logic [7:0]        delay_q;
  logic [7:0]        sound_q;

  assign sp_m1 = sp_q - SP_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        regs_a_q[i] <= 8'd0;
        regs_b_q[i] <= 8'd0;
      end
      index_q <= 12'd0;
      pc_q    <= PC_RESET;
      sp_q    <= '0;
      delay_q <= 8'd0;
      sound_q <= 8'd0;
    end else if (commit_i) begin
      for (int i = 0; i < 16; i++) begin
        if (upd_i.flag_we && 4'(i) == REG_FLAG) begin
          regs_a_q[i] <= upd_i.flag_data;
          regs_b_q[i] <= upd_i.flag_data;
        end else if (upd_i.reg_we && 4'(i) == upd_i.reg_num) begin
          regs_a_q[i] <= upd_i.reg_data;
          regs_b_q[i] <= upd_i.reg_data;
        end
      end
      pc_q <= upd_i.pc;
      if (upd_i.index_we) begin
        index_q <= upd_i.index;
      end
      if (upd_i.push) begin
        sp_q <= sp_q + SP_W'(1);
      end else if (upd_i.pop) begin
        sp_q <= sp_m1;
      end
      if (upd_i.delay_we) begin
        delay_q <= upd_i.timer_data;
      end
      if (upd_i.sound_we) begin
        sound_q <= upd_i.timer_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i && upd_i.push) begin
      stack_q[sp_q[SIDX_W-1:0]] <= upd_i.push_data;
    end
  end

  always_comb begin
    view_o.vx        = regs_a_q[rd_x_i];
    view_o.vy        = regs_b_q[rd_y_i];
    view_o.v0        = regs_a_q[0];
    view_o.vf        = regs_a_q[15];
    view_o.pc        = pc_q;
    view_o.index     = index_q;
    view_o.sp        = sp_q;
    view_o.stack_top = stack_q[sp_m1[SIDX_W-1:0]];
    view_o.delay     = delay_q;
    view_o.sound     = sound_q;
  end

endmodule

### rtl/chip8_cpu_execute_top.sv
// an accepted word waits in the input register until its result is registered
// throughput: one instruction per cycle while the output is not stalled, bounded
//   by the single execute stage between the input register and the result register
// reset: asynchronous active low; registers, index, timers and stack pointer
//   clear, program counter loads 0x200; call stack contents are not cleared
module chip8_cpu_execute_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // instruction[15:0], random_byte[23:16]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o   // next_pc[11:0], status[14:12], index_value[26:15],
                                       // reg_write_enable[27], reg_write_number[31:28],
                                       // reg_write_data[39:32], flag_value[47:40],
                                       // delay_value[55:48], sound_value[63:56]
);
  import c8x_pkg::*;

  logic        in_vld_q;
  logic [15:0] instr_q;
  logic [7:0]  rnd_q;
  logic        out_vld_q;
  result_t     res_q;
  result_t     res_d;
  update_t     upd;
  view_t       view;
  logic        adv;

  assign adv             = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      instr_q <= s_axis_tdata_i[15:0];
      rnd_q   <= s_axis_tdata_i[23:16];
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  c8x_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (adv),
    .rd_x_i   (instr_q[11:8]),
    .rd_y_i   (instr_q[7:4]),
    .upd_i    (upd),
    .view_o   (view)
  );

  c8x_exec u_exec (
    .instr_i (instr_q),
    .rnd_i   (rnd_q),
    .view_i  (view),
    .upd_o   (upd),
    .res_o   (res_d)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {res_q.sound_value, res_q.delay_value, res_q.flag_value,
                            res_q.reg_write_data, res_q.reg_write_number,
                            res_q.reg_write_enable, res_q.index_value, res_q.status,
                            res_q.next_pc};

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    view.sp <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_vld_q && m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without output back-pressure");

  a_fault_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (res_d.status == ST_OVERFLOW || res_d.status == ST_UNDERFLOW ||
             res_d.status == ST_UNKNOWN))
    |=> (view.pc == $past(view.pc) && view.sp == $past(view.sp) && m_axis_tvalid_o))
    else $error("faulting instruction changed state");

  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && upd.push) |=> view.sp == $past(view.sp) + SP_W'(1))
    else $error("call did not advance stack pointer");

endmodule

### test/chip8_cpu_execute_checker.sv
`timescale 1ns / 1ps

module chip8_cpu_execute_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [23:0] s_tdata_i,   // instruction[15:0], random_byte[23:16]
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [63:0] m_tdata_i,   // next_pc, status, index_value, reg_write_enable,
                                   // reg_write_number, reg_write_data, flag_value,
                                   // delay_value, sound_value
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  import c8x_pkg::*;

  logic [7:0]  vreg [16];
  logic [11:0] index_q;
  logic [11:0] pc_q;
  logic [11:0] call_stack [STACK_DEPTH];
  int unsigned sp_q;
  logic [7:0]  delay_q;
  logic [7:0]  sound_q;

  result_t     pending_results [$];
  result_t     want;
  result_t     got;
  int unsigned errors = 0;

  assign fail_count_o = errors;

  function automatic result_t execute_word(input logic [15:0] ins, input logic [7:0] rnd);
    logic [3:0]  top;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  n;
    logic [7:0]  nn;
    logic [11:0] nnn;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [8:0]  sum;
    logic [11:0] pc2;
    logic [11:0] npc;
    logic        wr;
    logic        fwr;
    logic [7:0]  wval;
    logic [7:0]  fval;
    status_e     st;
    result_t     r;
    top  = ins[15:12];
    x    = ins[11:8];
    y    = ins[7:4];
    n    = ins[3:0];
    nn   = ins[7:0];
    nnn  = ins[11:0];
    vx   = vreg[x];
    vy   = vreg[y];
    st   = ST_OK;
    wr   = 1'b0;
    fwr  = 1'b0;
    wval = '0;
    fval = '0;
    pc2  = pc_q + 12'd2;
    npc  = pc2;
    case (top)
      OP_SYS: begin
        if (ins == INS_CLS) begin
          st = ST_UNSUPPORTED;
        end else if (ins == INS_RET) begin
          if (sp_q == 0) begin
            st = ST_UNDERFLOW;
          end else begin
            sp_q = sp_q - 1;
            npc = call_stack[sp_q];
          end
        end else begin
          st = ST_UNKNOWN;
        end
      end
      OP_JP: npc = nnn;
      OP_CALL: begin
        if (sp_q >= STACK_DEPTH) begin
          st = ST_OVERFLOW;
        end else begin
          call_stack[sp_q] = pc2;
          sp_q = sp_q + 1;
          npc = nnn;
        end
      end
      OP_SE_I:  npc = pc_q + ((vx == nn) ? 12'd4 : 12'd2);
      OP_SNE_I: npc = pc_q + ((vx != nn) ? 12'd4 : 12'd2);
      OP_SE_R:  npc = pc_q + ((vx == vy) ? 12'd4 : 12'd2);
      OP_SNE_R: npc = pc_q + ((vx != vy) ? 12'd4 : 12'd2);
      OP_LD_I: begin
        wr = 1'b1;
        wval = nn;
      end
      OP_ADD_I: begin
        if (x != REG_FLAG) begin
          wr = 1'b1;
          wval = vx + nn;
        end
      end
      OP_ALU: begin
        case (n)
          ALU_LD: begin
            wr = 1'b1;
            wval = vy;
          end
          ALU_OR: begin
            wr = 1'b1;
            wval = vx | vy;
          end
          ALU_AND: begin
            wr = 1'b1;
            wval = vx & vy;
          end
          ALU_XOR: begin
            wr = 1'b1;
            wval = vx ^ vy;
          end
          ALU_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            wr = 1'b1;
            wval = sum[7:0];
            fwr = 1'b1;
            fval = {7'd0, sum[8]};
          end
          ALU_SUB: begin
            wr = 1'b1;
            wval = vx - vy;
            fwr = 1'b1;
            fval = {7'd0, vx >= vy};
          end
          ALU_SHR: begin
            wr = 1'b1;
            wval = vx >> 1;
            fwr = 1'b1;
            fval = {7'd0, vx[0]};
          end
          ALU_SUBN: begin
            wr = 1'b1;
            wval = vy - vx;
            fwr = 1'b1;
            fval = {7'd0, vy >= vx};
          end
          ALU_SHL: begin
            wr = 1'b1;
            wval = vx << 1;
            fwr = 1'b1;
            fval = {7'd0, vx[7]};
          end
          default: st = ST_UNKNOWN;
        endcase
      end
      OP_LD_IX: index_q = nnn;
      OP_JP_V0: npc = {4'd0, vreg[0]} + nnn;
      OP_RND: begin
        wr = 1'b1;
        wval = rnd & nn;
      end
      OP_DRW: st = ST_UNSUPPORTED;
      OP_KEY: st = (nn == KEY_SKP || nn == KEY_SKNP) ? ST_UNSUPPORTED : ST_UNKNOWN;
      default: begin
        case (nn)
          FN_LD_VX_DT: begin
            wr = 1'b1;
            wval = delay_q;
          end
          FN_LD_DT: delay_q = vx;
          FN_LD_ST: sound_q = vx;
          FN_LD_K, FN_ADD_I, FN_LD_F, FN_LD_B, FN_ST_REGS, FN_LD_REGS: st = ST_UNSUPPORTED;
          default: st = ST_UNKNOWN;
        endcase
      end
    endcase

    // faulting words leave the counter and the registers alone
    if (st == ST_UNKNOWN || st == ST_OVERFLOW || st == ST_UNDERFLOW) begin
      npc = pc_q;
      wr = 1'b0;
      fwr = 1'b0;
    end

    if (wr) vreg[x] = wval;
    if (fwr) vreg[REG_FLAG] = fval;
    if (wr) wval = vreg[x];
    pc_q = npc;

    r.next_pc          = pc_q;
    r.status           = st;
    r.index_value      = index_q;
    r.reg_write_enable = wr;
    r.reg_write_number = wr ? x : 4'd0;
    r.reg_write_data   = wr ? wval : 8'd0;
    r.flag_value       = vreg[REG_FLAG];
    r.delay_value      = delay_q;
    r.sound_value      = sound_q;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [11:0] exp_v,
                                      input logic [11:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) vreg[i] = '0;
      index_q = '0;
      pc_q    = PC_RESET;
      sp_q    = 0;
      delay_q = '0;
      sound_q = '0;
      pending_results.delete();
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.next_pc          = m_tdata_i[11:0];
        got.status           = m_tdata_i[14:12];
        got.index_value      = m_tdata_i[26:15];
        got.reg_write_enable = m_tdata_i[27];
        got.reg_write_number = m_tdata_i[31:28];
        got.reg_write_data   = m_tdata_i[39:32];
        got.flag_value       = m_tdata_i[47:40];
        got.delay_value      = m_tdata_i[55:48];
        got.sound_value      = m_tdata_i[63:56];
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, actual %h", $time, m_tdata_i);
        end else begin
          want = pending_results.pop_front();
          check_field("next_pc", want.next_pc, got.next_pc);
          check_field("status", want.status, got.status);
          check_field("index_value", want.index_value, got.index_value);
          check_field("reg_write_enable", want.reg_write_enable, got.reg_write_enable);
          check_field("reg_write_number", want.reg_write_number, got.reg_write_number);
          check_field("reg_write_data", want.reg_write_data, got.reg_write_data);
          check_field("flag_value", want.flag_value, got.flag_value);
          check_field("delay_value", want.delay_value, got.delay_value);
          check_field("sound_value", want.sound_value, got.sound_value);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        pending_results.push_back(execute_word(s_tdata_i[15:0], s_tdata_i[23:16]));
      end
      pending_o <= pending_results.size();
    end
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import c8x_pkg::*;

  localparam int RANDOM_WORDS = 1120;

  logic        clk_i;
  logic        rst_n    = 1'b0;
  logic        s_valid  = 1'b0;
  logic [23:0] s_data   = '0;
  logic        m_ready  = 1'b0;
  logic        idle_on  = 1'b1;
  logic        s_ready;
  logic        m_valid;
  logic [63:0] m_data;
  int unsigned pending;
  int unsigned fail_count;
  int          stall_cnt = 0;

  chip8_cpu_execute_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  chip8_cpu_execute_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_data),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("** chip8_cpu_execute_top: FAILED **");
    $finish;
  end

  // result side back-pressure in bursts
  always @(posedge clk_i) begin
    if (stall_cnt != 0) begin
      stall_cnt = stall_cnt - 1;
      m_ready <= (stall_cnt == 0);
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_cnt = $urandom_range(1, 18);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  task automatic push_word(input logic [15:0] ins, input logic [7:0] rnd);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {rnd, ins};
    do @(posedge clk_i); while (!s_ready);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h01;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  alu_n;
    logic [7:0]  fn;
    logic [11:0] addr;
    int          sel;
    x    = 4'($urandom_range(0, 15));
    y    = 4'($urandom_range(0, 15));
    addr = 12'($urandom_range(0, 4095));
    sel  = $urandom_range(0, 99);
    if (sel < 12) begin
      return {OP_LD_I, x, any_byte()};
    end else if (sel < 37) begin
      case ($urandom_range(0, 9))
        8: alu_n = ALU_SHL;
        9: alu_n = 4'($urandom_range(0, 15));
        default: alu_n = 4'($urandom_range(0, 7));
      endcase
      return {OP_ALU, x, y, alu_n};
    end else if (sel < 45) begin
      return {OP_ADD_I, x, any_byte()};
    end else if (sel < 55) begin
      case ($urandom_range(0, 3))
        0: return {OP_SE_I, x, any_byte()};
        1: return {OP_SNE_I, x, any_byte()};
        2: return {OP_SE_R, x, y, 4'($urandom_range(0, 15))};
        default: return {OP_SNE_R, x, y, 4'($urandom_range(0, 15))};
      endcase
    end else if (sel < 65) begin
      return ($urandom_range(0, 1) == 0) ? {OP_CALL, addr} : INS_RET;
    end else if (sel < 70) begin
      return ($urandom_range(0, 1) == 0) ? {OP_JP, addr} : {OP_JP_V0, addr};
    end else if (sel < 78) begin
      return ($urandom_range(0, 1) == 0) ? {OP_LD_IX, addr} : {OP_RND, x, any_byte()};
    end else if (sel < 88) begin
      case ($urandom_range(0, 10))
        0: fn = FN_LD_VX_DT;
        1: fn = FN_LD_DT;
        2: fn = FN_LD_ST;
        3: fn = FN_LD_K;
        4: fn = FN_ADD_I;
        5: fn = FN_LD_F;
        6: fn = FN_LD_B;
        7: fn = FN_ST_REGS;
        8: fn = FN_LD_REGS;
        9: fn = 8'($urandom_range(0, 255));
        default: fn = FN_LD_ST;
      endcase
      return {OP_MISC, x, fn};
    end else if (sel < 93) begin
      case ($urandom_range(0, 5))
        0: return INS_CLS;
        1: return {OP_SYS, addr};
        2: return {OP_DRW, addr};
        3: return {OP_KEY, x, KEY_SKP};
        4: return {OP_KEY, x, KEY_SKNP};
        default: return {OP_KEY, x, any_byte()};
      endcase
    end else begin
      return 16'($urandom_range(0, 65535));
    end
  endfunction

  initial begin : stimulus
    int sent;
    int next_phase;
    sent = 0;
    next_phase = 0;
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // return on an empty stack, screen clear, stray system word
    push_word(INS_RET, 8'h00);
    push_word(INS_CLS, 8'hFF);
    push_word({OP_SYS, 12'h123}, 8'h00);
    // add with carry, shift left from bit 7, flag register as destination
    push_word({OP_LD_I, 4'h0, 8'hFF}, 8'h00);
    push_word({OP_LD_I, 4'h1, 8'h01}, 8'h00);
    push_word({OP_ALU, 4'h0, 4'h1, ALU_ADD}, 8'h00);
    push_word({OP_LD_I, 4'h0, 8'h80}, 8'h00);
    push_word({OP_ALU, 4'h0, 4'h0, ALU_SHL}, 8'h00);
    push_word({OP_ALU, REG_FLAG, 4'h1, ALU_SHR}, 8'h00);
    push_word({OP_ADD_I, REG_FLAG, 8'h55}, 8'h00);
    push_word({OP_ADD_I, 4'h0, 8'hFF}, 8'h00);
    // register skips with a nonzero low nibble
    push_word({OP_SE_R, 4'h0, 4'h1, 4'h9}, 8'h00);
    push_word({OP_SNE_R, 4'h0, 4'h1, 4'h2}, 8'h00);
    push_word({OP_SE_I, 4'h0, 8'hFF}, 8'h00);
    push_word({OP_ALU, 4'h1, 4'h1, ALU_SUB}, 8'h00);
    push_word({OP_ALU, 4'h0, 4'h1, ALU_SUBN}, 8'h00);
    push_word({OP_ALU, 4'h0, 4'h1, 4'hD}, 8'h00);
    push_word({OP_LD_IX, 12'hFFF}, 8'h00);
    push_word({OP_JP_V0, 12'hFFF}, 8'h00);
    push_word({OP_RND, 4'h2, 8'hAA}, 8'hF0);
    push_word({OP_DRW, 12'h123}, 8'h00);
    push_word({OP_KEY, 4'h1, KEY_SKP}, 8'h00);
    push_word({OP_KEY, 4'hF, KEY_SKNP}, 8'h00);
    push_word({OP_MISC, 4'h0, FN_LD_DT}, 8'h00);
    push_word({OP_MISC, 4'h2, FN_LD_ST}, 8'h00);
    push_word({OP_MISC, 4'h3, FN_LD_VX_DT}, 8'h00);
    push_word({OP_MISC, 4'h1, FN_LD_K}, 8'h00);
    push_word({OP_CALL, 12'hFFE}, 8'h00);
    push_word(INS_RET, 8'h00);
    drain();

    while (sent < RANDOM_WORDS) begin
      if (sent >= next_phase) begin
        idle_on <= (sent + 150 < RANDOM_WORDS) && ($urandom_range(0, 3) != 0);
        next_phase = next_phase + 100;
      end
      if ($urandom_range(0, 199) == 0) begin
        drain();
      end
      if ($urandom_range(0, 149) == 0) begin
        // fill the stack past its depth, then unwind past empty
        repeat (STACK_DEPTH + 2) push_word({OP_CALL, 12'($urandom_range(0, 4095))},
                                           8'($urandom_range(0, 255)));
        repeat (STACK_DEPTH + 3) push_word(INS_RET, 8'($urandom_range(0, 255)));
        sent = sent + 2 * STACK_DEPTH + 5;
      end else begin
        push_word(pick_word(), 8'($urandom_range(0, 255)));
        sent = sent + 1;
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** chip8_cpu_execute_top: PASSED **");
    end else begin
      $display("** chip8_cpu_execute_top: FAILED **");
    end
    $finish;
  end

endmodule
